// ===== hw/rtl/matrix_max_diagonal_pair_difference_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the matrix max diagonal pair difference core
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MAX_DIAGONAL_PAIR_DIFFERENCE_CORE_MACROS_SVH
`define MATRIX_MAX_DIAGONAL_PAIR_DIFFERENCE_CORE_MACROS_SVH

// same-cycle implication
`define MMDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mmdp assertion failed");

// next-cycle implication
`define MMDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mmdp assertion failed");

`endif

// ===== hw/rtl/mmdp_pkg.sv =====
// ----------------------------------------------------------------------------
// mmdp_pkg
// Types and fixed constants for the matrix max diagonal pair difference core.
// ----------------------------------------------------------------------------
`default_nettype none

package mmdp_pkg;

	localparam int unsigned ROW_CNT_W  = 13;
	localparam int unsigned COL_CNT_W  = 11;
	localparam int unsigned ROW_POS_W  = 12;
	localparam int unsigned ROW_LIMIT  = 4096;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT    = 2'd0,
		REG_COLUMN_COUNT = 2'd1
	} cfg_reg_t;

	// per-element position flags handed from the sequencer to the datapath
	typedef struct packed {
		logic first_row;
		logic first_col;
		logic last;
	} elem_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/matrix_max_diagonal_pair_difference_core.sv =====
// ----------------------------------------------------------------------------
// matrix_max_diagonal_pair_difference_core
// Streaming search for the largest lower-right minus upper-left element pair.
// ----------------------------------------------------------------------------
// Usage:
//   Program row_count (index 0) and column_count (index 1) over the cfg
//   channel while idle; cfg_ready is always high and any register write
//   drops the matrix in progress. Then stream the matrix in row-major order
//   on in_valid/in_stall/element_value, one element per transfer.
//   On the last element one result transfer goes out on out_valid/out_stall
//   with best_difference and pair_found; a matrix with one row or one column
//   reports pair_found = 0 and best_difference = 0.
//   Throughput: one element per cycle unless in_stall holds it. The row buffer
//   of prefix minima sits in a registered-read RAM, read on accept and
//   written back from the s1 stage when that stage advances. The result is
//   registered into the output register as the last element leaves s1.
//   A stalled result is held; in_stall rises only when a further matrix end
//   reaches a full, stalled output register.
//   Reset: counts return to 1, positions and the running best clear. The row
//   buffer needs no clearing since values read during the first row go unused.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_max_diagonal_pair_difference_core
	import mmdp_pkg::*;
#(
	parameter int MAX_COLUMNS = 1024,
	parameter int VALUE_BITS  = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [VALUE_BITS-1:0]   element_value,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic      [VALUE_BITS:0]     best_difference,
	output logic                         pair_found
);

	localparam int AW = $clog2(MAX_COLUMNS);

	logic                  in_accept;
	logic                  cfg_clear;
	logic [AW-1:0]         col_pos;
	elem_ctl_t             ctl;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [VALUE_BITS-1:0] wr_data;
	logic [VALUE_BITS-1:0] rd_data;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && !in_stall;

	mmdp_seq #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_accept(in_accept),
		.col_pos  (col_pos),
		.ctl      (ctl),
		.cfg_clear(cfg_clear)
	);

	mmdp_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(MAX_COLUMNS)
	) u_row_buf (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (in_accept),
		.rd_addr(col_pos),
		.rd_data(rd_data)
	);

	mmdp_dp #(
		.W (VALUE_BITS),
		.AW(AW)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_clear      (cfg_clear),
		.in_accept      (in_accept),
		.element_value  (element_value),
		.rd_addr        (col_pos),
		.ctl            (ctl),
		.rd_data        (rd_data),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.wr_data        (wr_data),
		.in_stall       (in_stall),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.best_difference(best_difference),
		.pair_found     (pair_found)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/mmdp_ram.sv =====
// ----------------------------------------------------------------------------
// mmdp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mmdp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mmdp_seq.sv =====
// ----------------------------------------------------------------------------
// mmdp_seq
// Configuration registers and row/column position tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module mmdp_seq
	import mmdp_pkg::*;
#(
	parameter int MAX_COLUMNS = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [CFG_DATA_W-1:0]          cfg_data,
	input  wire logic                           in_accept,
	output logic      [$clog2(MAX_COLUMNS)-1:0] col_pos,
	output elem_ctl_t                           ctl,
	output logic                                cfg_clear
);

	localparam int AW = $clog2(MAX_COLUMNS);

	logic [ROW_CNT_W-1:0] row_count_q;
	logic [COL_CNT_W-1:0] column_count_q;
	logic [ROW_POS_W-1:0] row_q;
	logic [AW-1:0]        col_q;
	logic [ROW_POS_W-1:0] last_row;
	logic [AW-1:0]        last_col;
	logic                 wr_row;
	logic                 wr_col;

	assign wr_row    = cfg_valid && (cfg_index == REG_ROW_COUNT);
	assign wr_col    = cfg_valid && (cfg_index == REG_COLUMN_COUNT);
	assign cfg_clear = wr_row || wr_col;

	// zero counts act as one, oversized counts saturate
	always_comb begin
		if (row_count_q == '0) begin
			last_row = '0;
		end else if (32'(row_count_q) > 32'(ROW_LIMIT)) begin
			last_row = ROW_POS_W'(ROW_LIMIT - 1);
		end else begin
			last_row = ROW_POS_W'(row_count_q - ROW_CNT_W'(1));
		end
		if (column_count_q == '0) begin
			last_col = '0;
		end else if (32'(column_count_q) > 32'(MAX_COLUMNS)) begin
			last_col = AW'(MAX_COLUMNS - 1);
		end else begin
			last_col = AW'(column_count_q - COL_CNT_W'(1));
		end
	end

	assign col_pos       = col_q;
	assign ctl.first_row = (row_q == '0);
	assign ctl.first_col = (col_q == '0);
	assign ctl.last      = (row_q == last_row) && (col_q == last_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= ROW_CNT_W'(1);
			column_count_q <= COL_CNT_W'(1);
			row_q          <= '0;
			col_q          <= '0;
		end else begin
			if (wr_row) begin
				row_count_q <= cfg_data[ROW_CNT_W-1:0];
			end
			if (wr_col) begin
				column_count_q <= cfg_data[COL_CNT_W-1:0];
			end
			if (cfg_clear) begin
				row_q <= '0;
				col_q <= '0;
			end else if (in_accept) begin
				if (col_q == last_col) begin
					col_q <= '0;
					row_q <= (row_q == last_row) ? '0 : row_q + ROW_POS_W'(1);
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mmdp_dp.sv =====
// ----------------------------------------------------------------------------
// mmdp_dp
// Read-modify-write stage on the row buffer, best tracking and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmdp_dp
	import mmdp_pkg::*;
#(
	parameter int W  = 32,
	parameter int AW = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_clear,
	input  wire logic          in_accept,
	input  wire logic [W-1:0]  element_value,
	input  wire logic [AW-1:0] rd_addr,
	input  wire elem_ctl_t     ctl,
	input  wire logic [W-1:0]  rd_data,
	output logic               wr_en,
	output logic      [AW-1:0] wr_addr,
	output logic      [W-1:0]  wr_data,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic      [W:0]    best_difference,
	output logic               pair_found
);

	logic                valid_s1;
	logic signed [W-1:0] v_s1;
	logic [AW-1:0]       col_s1;
	elem_ctl_t           ctl_s1;

	logic signed [W-1:0] rmin_q;
	logic signed [W-1:0] diag_q;
	logic signed [W:0]   best_q;
	logic                found_q;
	logic                fwd_q;
	logic signed [W-1:0] fwd_data_q;

	logic                out_valid_q;
	logic [W:0]          best_out_q;
	logic                found_out_q;

	logic signed [W-1:0] above;
	logic signed [W-1:0] rmin_nx;
	logic signed [W-1:0] rect;
	logic signed [W:0]   cand;
	logic                pair;
	logic                take;
	logic signed [W:0]   best_nx;
	logic                found_nx;
	logic                adv;

	always_comb begin
		// RAM returns old data when the entry was written on the read edge
		above    = fwd_q ? fwd_data_q : $signed(rd_data);
		rmin_nx  = (ctl_s1.first_col || (v_s1 < rmin_q)) ? v_s1 : rmin_q;
		rect     = (ctl_s1.first_row || (rmin_nx < above)) ? rmin_nx : above;
		pair     = !ctl_s1.first_row && !ctl_s1.first_col;
		cand     = $signed({v_s1[W-1], v_s1}) - $signed({diag_q[W-1], diag_q});
		take     = pair && (!found_q || (cand > best_q));
		best_nx  = take ? cand : best_q;
		found_nx = found_q || pair;
		adv      = valid_s1 && !(ctl_s1.last && out_valid_q && out_stall);
	end

	assign in_stall        = valid_s1 && !adv;
	assign wr_en           = adv;
	assign wr_addr         = col_s1;
	assign wr_data         = rect;
	assign out_valid       = out_valid_q;
	assign best_difference = best_out_q;
	assign pair_found      = found_out_q;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			v_s1       <= $signed(element_value);
			col_s1     <= rd_addr;
			ctl_s1     <= ctl;
			fwd_data_q <= rect;
		end
		if (adv && ctl_s1.last) begin
			best_out_q  <= found_nx ? best_nx : '0;
			found_out_q <= found_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			rmin_q      <= '0;
			diag_q      <= '0;
			best_q      <= '0;
			found_q     <= 1'b0;
			fwd_q       <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			fwd_q <= in_accept && adv && (col_s1 == rd_addr);

			if (cfg_clear) begin
				best_q  <= '0;
				found_q <= 1'b0;
			end else if (adv) begin
				rmin_q <= rmin_nx;
				diag_q <= above;
				if (ctl_s1.last) begin
					best_q  <= '0;
					found_q <= 1'b0;
				end else begin
					best_q  <= best_nx;
					found_q <= found_nx;
				end
			end

			if (adv && ctl_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mmdp_checker.sv =====
// ----------------------------------------------------------------------------
// mmdp_checker
// Port-level assertions for the matrix max diagonal pair difference core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_max_diagonal_pair_difference_core_macros.svh"

module mmdp_checker #(
	parameter int VALUE_BITS = 32
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [VALUE_BITS:0]   best_difference,
	input wire logic                  pair_found
);

	// a held result stays up
	`MMDP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	// no pair means a zero difference
	`MMDP_ASSERT_NOW(a_zero_no_pair, clk, arst_n, out_valid && !pair_found, best_difference == '0)
	// input backpressure only comes from a stalled result
	`MMDP_ASSERT_NOW(a_stall_cause, clk, arst_n, in_valid && in_stall, out_valid && out_stall)
	// register writes always complete
	`MMDP_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind matrix_max_diagonal_pair_difference_core mmdp_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_mmdp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cfg_valid      (cfg_valid),
	.cfg_ready      (cfg_ready),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.best_difference(best_difference),
	.pair_found     (pair_found)
);

`default_nettype wire
